// ===== rtl/core/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 7;
    localparam int ST_W    = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        logic shift_in;
        logic tail_load;
        logic shift_out;
    } t_cell_ctl;

endpackage

// ===== rtl/core/deq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue chain. Shifts toward the back on a front
// push, toward the front on a front pop, and loads the word on a back push
// when it sits just past the last entry.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int OCC_W = 7
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [OCC_W-1:0] i_occ,
    input  t_word            i_value,
    input  t_word            i_left,
    input  t_word            i_right,
    output t_word            o_data,
    output t_word            o_leaf
);

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_in) begin
            n_data = i_left;
        end else if (i_ctl.shift_out) begin
            n_data = i_right;
        end else if (i_ctl.tail_load && (i_occ == OCC_W'(IDX))) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // only the back entry feeds the reduction tree
    assign o_leaf = (i_occ == OCC_W'(IDX + 1)) ? r_data : '0;

endmodule

// ===== rtl/core/deq_or_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_or_tree
// Registered binary OR tree that picks out the one nonzero leaf word.
// One register stage per level.
// ----------------------------------------------------------------------------
module deq_or_tree
    import deq_pkg::*;
#(
    parameter int LEVELS = 6
) (
    input  logic                                 i_clk,
    input  logic [(2**LEVELS)-1:0][WORD_W-1:0]   i_leaf,
    output t_word                                o_root
);

    localparam int N_LEAF = 2 ** LEVELS;
    localparam int N_NODE = N_LEAF - 1;

    logic [N_NODE-1:0][WORD_W-1:0]      r_node;
    logic [N_NODE+N_LEAF-1:0][WORD_W-1:0] w_all;

    genvar k;
    generate
        for (k = 0; k < N_NODE; k++) begin : g_node_tap
            assign w_all[k] = r_node[k];
        end
        for (k = 0; k < N_LEAF; k++) begin : g_leaf_tap
            assign w_all[N_NODE+k] = i_leaf[k];
        end
        for (k = 0; k < N_NODE; k++) begin : g_node
            always_ff @(posedge i_clk) begin
                r_node[k] <= w_all[2*k+1] | w_all[2*k+2];
            end
        end
    endgenerate

    assign o_root = r_node[0];

endmodule

// ===== rtl/core/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words held in a chain of shifting cells.
// Each result waits on the registered OR tree that finds the back entry,
//   then is registered at the output; a downstream stall holds it back.
// No new input beat is taken (o_stall high) until the last result is registered.
// Reset: synchronous active low; queue empty, no result pending.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic signed [31:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_popped_value,
    output logic signed [31:0]  o_front_value,
    output logic signed [31:0]  o_back_value,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic [ST_W-1:0]     o_status
);

    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = $clog2(CAPACITY);
    localparam int N_LEAF = 2 ** LEVELS;
    localparam int CNT_W  = $clog2(LEVELS + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    t_word            r_back;
    t_word            r_pop_pend;
    logic [ST_W-1:0]  r_st_pend;
    t_word            n_pop;
    logic [ST_W-1:0]  n_st;

    logic             r_out_valid;
    t_word            r_out_pop;
    t_word            r_out_front;
    t_word            r_out_back;
    logic [COUNT_W-1:0] r_out_count;
    logic [ST_W-1:0]  r_out_st;

    logic             w_accept;
    logic             w_done;
    logic             w_full;
    logic             w_empty;
    t_cell_ctl        w_ctl;
    t_word            w_root;
    logic [OCC_W+COUNT_W-1:0] w_count_ext;

    t_word                         w_data [CAPACITY];
    logic [N_LEAF-1:0][WORD_W-1:0] w_leaf;

    assign w_accept = i_valid && !r_busy;
    assign w_done   = r_busy && (r_cnt == '0) && (!r_out_valid || !i_stall);
    assign w_full   = (r_occ == OCC_W'(CAPACITY));
    assign w_empty  = (r_occ == '0);

    always_comb begin
        w_ctl = '0;
        n_occ = r_occ;
        n_pop = '0;
        n_st  = ST_OK;
        case (i_op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (w_full) begin
                    n_st = ST_FULL;
                end else begin
                    w_ctl.shift_in  = (i_op == OP_PUSH_FRONT);
                    w_ctl.tail_load = (i_op == OP_PUSH_BACK);
                    n_occ = r_occ + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (w_empty) begin
                    n_st = ST_EMPTY;
                end else begin
                    w_ctl.shift_out = (i_op == OP_POP_FRONT);
                    n_pop = (i_op == OP_POP_FRONT) ? w_data[0] : r_back;
                    n_occ = r_occ - 1'b1;
                end
            end
            default: begin
                n_st = ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_ctl = '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            t_word w_left;
            t_word w_right;
            t_word w_cell_leaf;
            if (i == 0) begin : g_first
                assign w_left = i_value;
            end else begin : g_mid_l
                assign w_left = w_data[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[i+1];
            end
            deq_cell #(
                .IDX   (i),
                .OCC_W (OCC_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_occ   (r_occ),
                .i_value (i_value),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[i]),
                .o_leaf  (w_cell_leaf)
            );
            assign w_leaf[i] = w_cell_leaf;
        end
        for (i = CAPACITY; i < N_LEAF; i++) begin : g_pad
            assign w_leaf[i] = '0;
        end
    endgenerate

    deq_or_tree #(
        .LEVELS (LEVELS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(LEVELS);
                r_occ  <= n_occ;
            end else begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end
                if (w_done) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_count_ext = {{COUNT_W{1'b0}}, r_occ};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_pend <= n_pop;
            r_st_pend  <= n_st;
        end
        if (w_done) begin
            r_back      <= w_root;
            r_out_pop   <= r_pop_pend;
            r_out_st    <= r_st_pend;
            r_out_front <= w_empty ? '0 : w_data[0];
            r_out_back  <= w_root;
            r_out_count <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_stall        = r_busy;
    assign o_valid        = r_out_valid;
    assign o_popped_value = r_out_pop;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_entry_count  = r_out_count;
    assign o_status       = r_out_st;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && (r_cnt == CNT_W'(LEVELS)))
        else $error("accepted beat did not start the tree wait");

    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> r_busy)
        else $error("tree wait counting while idle");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |->
            (o_entry_count == '0) && (o_popped_value == '0) &&
            (o_front_value == '0) && (o_back_value == '0))
        else $error("empty pop result carries data");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> o_valid && !r_busy)
        else $error("finished beat not presented");

endmodule
